// ===== hw/rtl/cafa_pkg.sv =====
package cafa_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CROSS_BITS     = 40;
  localparam int MIN_AREA_W     = 13;
  localparam int ASPECT_W       = 9;
  localparam int PERCENT_SCALE  = 100;
  localparam int SCALE_W        = 7;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST = 13'd500;
  localparam logic [ASPECT_W-1:0]   ASPECT_RST   = 9'd100;

  typedef enum logic {
    REG_MIN_AREA = 1'b0,
    REG_ASPECT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MIN_AREA_W-1:0] min_area;
    logic [ASPECT_W-1:0]   aspect_percent;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

// ===== hw/rtl/contour_area_aspect_filter_top.sv =====
// a verdict is valid once the last vertex transaction has reached the result register
// throughput: one vertex per cycle while in_stall is low, set by the four-register
// pipeline (input, cross products and box, accumulator, result)
// in_stall rises only while a verdict waits behind a stalled result
// rst_n synchronously clears the pipeline, the accumulator and the contour state,
// and returns min_area to 500 and aspect_percent to 100
module contour_area_aspect_filter_top
  import cafa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_person,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int C = COORD_BITS;

  cfg_t                  cfg;
  logic                  hold, adv;
  ctl_t                  p_ctl, a_ctl;
  logic [2*C:0]          p_step, p_close;
  logic [C-1:0]          p_dx, p_dy;
  logic [CROSS_BITS-1:0] a_total;
  logic                  a_dx_nz;
  logic [C+SCALE_W-1:0]  a_dy_scaled;
  logic [C+ASPECT_W-1:0] a_dx_scaled;

  assign adv      = ~hold;
  assign in_stall = hold;

  cafa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cafa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_last_point (in_last_point),
    .p_ctl         (p_ctl),
    .p_step        (p_step),
    .p_close       (p_close),
    .p_dx          (p_dx),
    .p_dy          (p_dy)
  );

  cafa_accum #(.COORD_BITS(COORD_BITS)) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (cfg),
    .p_ctl       (p_ctl),
    .p_step      (p_step),
    .p_close     (p_close),
    .p_dx        (p_dx),
    .p_dy        (p_dy),
    .a_ctl       (a_ctl),
    .a_total     (a_total),
    .a_dx_nz     (a_dx_nz),
    .a_dy_scaled (a_dy_scaled),
    .a_dx_scaled (a_dx_scaled)
  );

  cafa_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .a_ctl         (a_ctl),
    .a_total       (a_total),
    .a_dx_nz       (a_dx_nz),
    .a_dy_scaled   (a_dy_scaled),
    .a_dx_scaled   (a_dx_scaled),
    .hold          (hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_person (out_is_person)
  );

endmodule

// ===== hw/rtl/cafa_regs.sv =====
module cafa_regs
  import cafa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_area       <= MIN_AREA_RST;
      cfg_r.aspect_percent <= ASPECT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_AREA: cfg_r.min_area       <= pwdata[MIN_AREA_W-1:0];
        REG_ASPECT:   cfg_r.aspect_percent <= pwdata[ASPECT_W-1:0];
        default:      cfg_r.min_area       <= cfg_r.min_area;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_AREA: prdata = {{(DATA_W-MIN_AREA_W){1'b0}}, cfg_r.min_area};
      REG_ASPECT:   prdata = {{(DATA_W-ASPECT_W){1'b0}}, cfg_r.aspect_percent};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cafa_front.sv =====
module cafa_front
  import cafa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_last_point,
  output ctl_t                  p_ctl,
  output logic [2*COORD_BITS:0] p_step,
  output logic [2*COORD_BITS:0] p_close,
  output logic [COORD_BITS-1:0] p_dx,
  output logic [COORD_BITS-1:0] p_dy
);

  localparam int C = COORD_BITS;

  // input register
  ctl_t         i_ctl_r;
  logic [C-1:0] i_x_r, i_y_r;

  // contour state
  logic         in_contour_r;
  logic [C-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [C-1:0] min_x_r, min_y_r, max_x_r, max_y_r;

  ctl_t           p_ctl_r;
  logic [2*C:0]   p_step_r, p_close_r;
  logic [C-1:0]   p_dx_r, p_dy_r;

  logic           is_first;
  logic [C-1:0]   fx, fy;
  logic [C-1:0]   min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic [2*C-1:0] pa, pb, pc, pd;
  logic [2*C:0]   step_nxt, close_nxt;

  assign is_first = ~in_contour_r;
  assign fx = is_first ? i_x_r : first_x_r;
  assign fy = is_first ? i_y_r : first_y_r;

  assign pa = {{C{1'b0}}, prev_x_r} * {{C{1'b0}}, i_y_r};
  assign pb = {{C{1'b0}}, i_x_r} * {{C{1'b0}}, prev_y_r};
  assign pc = {{C{1'b0}}, i_x_r} * {{C{1'b0}}, fy};
  assign pd = {{C{1'b0}}, fx} * {{C{1'b0}}, i_y_r};

  assign step_nxt  = is_first ? '0 : ({1'b0, pa} - {1'b0, pb});
  // closing edge from this vertex back to the first one
  assign close_nxt = i_ctl_r.last ? ({1'b0, pc} - {1'b0, pd}) : '0;

  always_comb begin
    if (is_first) begin
      min_x_nxt = i_x_r;
      min_y_nxt = i_y_r;
      max_x_nxt = i_x_r;
      max_y_nxt = i_y_r;
    end else begin
      min_x_nxt = (i_x_r < min_x_r) ? i_x_r : min_x_r;
      min_y_nxt = (i_y_r < min_y_r) ? i_y_r : min_y_r;
      max_x_nxt = (i_x_r > max_x_r) ? i_x_r : max_x_r;
      max_y_nxt = (i_y_r > max_y_r) ? i_y_r : max_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_ctl_r      <= '0;
      p_ctl_r      <= '0;
      in_contour_r <= 1'b0;
    end else if (adv) begin
      i_ctl_r.valid <= in_valid;
      i_ctl_r.last  <= in_last_point;
      p_ctl_r       <= i_ctl_r;
      if (i_ctl_r.valid) begin
        in_contour_r <= ~i_ctl_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_x_r     <= in_point_x;
      i_y_r     <= in_point_y;
      p_step_r  <= step_nxt;
      p_close_r <= close_nxt;
      p_dx_r    <= max_x_nxt - min_x_nxt;
      p_dy_r    <= max_y_nxt - min_y_nxt;
      if (i_ctl_r.valid) begin
        prev_x_r  <= i_x_r;
        prev_y_r  <= i_y_r;
        first_x_r <= fx;
        first_y_r <= fy;
        min_x_r   <= min_x_nxt;
        min_y_r   <= min_y_nxt;
        max_x_r   <= max_x_nxt;
        max_y_r   <= max_y_nxt;
      end
    end
  end

  assign p_ctl   = p_ctl_r;
  assign p_step  = p_step_r;
  assign p_close = p_close_r;
  assign p_dx    = p_dx_r;
  assign p_dy    = p_dy_r;

endmodule

// ===== hw/rtl/cafa_accum.sv =====
module cafa_accum
  import cafa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  cfg_t                           cfg,
  input  ctl_t                           p_ctl,
  input  logic [2*COORD_BITS:0]          p_step,
  input  logic [2*COORD_BITS:0]          p_close,
  input  logic [COORD_BITS-1:0]          p_dx,
  input  logic [COORD_BITS-1:0]          p_dy,
  output ctl_t                           a_ctl,
  output logic [CROSS_BITS-1:0]          a_total,
  output logic                           a_dx_nz,
  output logic [COORD_BITS+SCALE_W-1:0]  a_dy_scaled,
  output logic [COORD_BITS+ASPECT_W-1:0] a_dx_scaled
);

  localparam int C   = COORD_BITS;
  localparam int EXT = CROSS_BITS - 2*C - 1;

  logic [CROSS_BITS-1:0]  sum_r;
  ctl_t                   a_ctl_r;
  logic [CROSS_BITS-1:0]  a_total_r;
  logic                   a_dx_nz_r;
  logic [C+SCALE_W-1:0]   a_dy_scaled_r;
  logic [C+ASPECT_W-1:0]  a_dx_scaled_r;

  logic [CROSS_BITS-1:0]  step_ext, close_ext, sum_nxt;

  assign step_ext  = {{EXT{p_step[2*C]}}, p_step};
  assign close_ext = {{EXT{p_close[2*C]}}, p_close};
  assign sum_nxt   = sum_r + step_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      a_ctl_r <= '0;
    end else if (adv) begin
      a_ctl_r <= p_ctl;
      if (p_ctl.valid) begin
        sum_r <= p_ctl.last ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_total_r     <= sum_nxt + close_ext;
      a_dx_nz_r     <= (p_dx != '0);
      a_dy_scaled_r <= {{SCALE_W{1'b0}}, p_dy} * (C+SCALE_W)'(PERCENT_SCALE);
      a_dx_scaled_r <= {{ASPECT_W{1'b0}}, p_dx} *
                       {{C{1'b0}}, cfg.aspect_percent};
    end
  end

  assign a_ctl       = a_ctl_r;
  assign a_total     = a_total_r;
  assign a_dx_nz     = a_dx_nz_r;
  assign a_dy_scaled = a_dy_scaled_r;
  assign a_dx_scaled = a_dx_scaled_r;

endmodule

// ===== hw/rtl/cafa_decide.sv =====
module cafa_decide
  import cafa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  ctl_t                           a_ctl,
  input  logic [CROSS_BITS-1:0]          a_total,
  input  logic                           a_dx_nz,
  input  logic [COORD_BITS+SCALE_W-1:0]  a_dy_scaled,
  input  logic [COORD_BITS+ASPECT_W-1:0] a_dx_scaled,
  output logic                           hold,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_person
);

  localparam int C = COORD_BITS;

  logic                  out_valid_r, out_is_person_r;
  logic [CROSS_BITS-1:0] mag, area_lim;
  logic [C+ASPECT_W-1:0] dy_ext;
  logic                  pass;

  assign mag      = a_total[CROSS_BITS-1] ? (~a_total + 1'b1) : a_total;
  assign area_lim = {{(CROSS_BITS-MIN_AREA_W-1){1'b0}}, cfg.min_area, 1'b0};
  assign dy_ext   = {{(ASPECT_W-SCALE_W){1'b0}}, a_dy_scaled};
  assign pass     = (mag > area_lim) & a_dx_nz & (dy_ext > a_dx_scaled);

  // a verdict stuck behind a stalled result freezes the pipeline
  assign hold = out_valid_r & out_stall & a_ctl.valid & a_ctl.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= a_ctl.valid & a_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_is_person_r <= pass;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_person = out_is_person_r;

endmodule
